/* rtl/rgb_to_hsv_pixel_defines.svh */
// ============================================================================
// RGB to HSV pixel converter: assertion macros
// Shared assertion forms, clocked on clk and held off while rst_n is low.
// ============================================================================
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define RTH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define RTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rth_pkg.sv */
// ============================================================================
// RGB to HSV pixel converter: package
// Widths, the divider lane types and the single restoring division step.
// ============================================================================
package rth_pkg;

    localparam int PIX_W = 8;              // one color channel
    localparam int QUO_W = 8;              // quotient bits of both divisions
    localparam int QIDX_W = $clog2(QUO_W); // index of one quotient bit
    localparam int NUM_W = 17;             // dividend, holds 85 * 1530
    localparam int DEN_W = PIX_W + 1;      // divisor, holds 2 * delta

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t        hue;
        div_lane_t        sat;
        logic [PIX_W-1:0] brightness;
    } div_stage_t;

    // One restoring step: try to take den * 2^shift from the remainder.
    function automatic div_lane_t div_step(input div_lane_t lane, input int shift);
        logic [NUM_W:0]    shifted;
        logic [NUM_W:0]    trial;
        logic [QIDX_W-1:0] qbit;
        div_lane_t         res;
        qbit    = QIDX_W'(shift);
        shifted = {{(NUM_W + 1 - DEN_W){1'b0}}, lane.den} << shift;
        trial   = {1'b0, lane.rem} - shifted;
        res     = lane;
        if (!trial[NUM_W])
        begin
            res.rem       = trial[NUM_W-1:0];
            res.quo[qbit] = 1'b1;
        end
        return res;
    endfunction

endpackage

/* rtl/rth_prep.sv */
// ============================================================================
// RGB to HSV pixel converter: front end
// Three stages: channel compare, sector angle, and the two dividends.
// ============================================================================
module rth_prep
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [rth_pkg::PIX_W-1:0]  red,
    input  logic [rth_pkg::PIX_W-1:0]  green,
    input  logic [rth_pkg::PIX_W-1:0]  blue,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rth_pkg::div_stage_t        out_data
);
    import rth_pkg::*;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // Stage A: largest, smallest, sector and channel difference.
    logic                     a_valid_reg;
    logic [PIX_W-1:0]         a_mx_reg;
    logic [PIX_W-1:0]         a_mn_reg;
    sector_t                  a_sector_reg;
    logic signed [PIX_W:0]    a_k_reg;
    logic [PIX_W-1:0]         a_mx_next;
    logic [PIX_W-1:0]         a_mn_next;
    sector_t                  a_sector_next;
    logic signed [PIX_W:0]    a_k_next;

    // Stage B: delta and the angle in units of 60 degrees over delta.
    logic                     b_valid_reg;
    logic [PIX_W-1:0]         b_mx_reg;
    logic [PIX_W-1:0]         b_delta_reg;
    logic [10:0]              b_x_reg;
    logic [PIX_W-1:0]         b_delta_next;
    logic [10:0]              b_x_next;

    // Stage C: dividends and divisors for both divisions.
    logic                     c_valid_reg;
    div_stage_t               c_data_reg;
    div_stage_t               c_data_next;

    logic                     a_ready;
    logic                     b_ready;
    logic                     c_ready;

    logic signed [11:0]       k_ext;
    logic signed [11:0]       base;
    logic signed [11:0]       six_d;
    logic signed [11:0]       x_sum;
    logic signed [11:0]       x_wrap;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // Ties favor red, then green, as the sector formula expects.
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            a_mx_next     = red;
            a_sector_next = SECT_RED;
            a_k_next      = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            a_mx_next     = green;
            a_sector_next = SECT_GREEN;
            a_k_next      = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            a_mx_next     = blue;
            a_sector_next = SECT_BLUE;
            a_k_next      = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        if (red <= green && red <= blue)
            a_mn_next = red;
        else if (green <= blue)
            a_mn_next = green;
        else
            a_mn_next = blue;
    end

    always_comb
    begin
        b_delta_next = a_mx_reg - a_mn_reg;
        k_ext        = {{3{a_k_reg[PIX_W]}}, a_k_reg};
        six_d        = $signed({2'b00, b_delta_next, 2'b00})
                     + $signed({3'b000, b_delta_next, 1'b0});
        case (a_sector_reg)
            SECT_RED:   base = '0;
            SECT_GREEN: base = $signed({3'b000, b_delta_next, 1'b0});
            SECT_BLUE:  base = $signed({2'b00, b_delta_next, 2'b00});
            default:    base = '0;
        endcase
        x_sum  = k_ext + base;
        x_wrap = k_ext + six_d;
        // Only the red sector can go negative; it wraps by a full turn.
        if (x_sum[11])
            b_x_next = x_wrap[10:0];
        else
            b_x_next = x_sum[10:0];
    end

    // Hue = floor(85 * x / (2 * delta)); a gray or black pixel divides
    // a zero dividend by a nonzero stand-in so the quotient comes out zero.
    always_comb
    begin
        c_data_next.hue.rem = {b_x_reg, 6'b0} + {2'b0, b_x_reg, 4'b0}
                            + {4'b0, b_x_reg, 2'b0} + {6'b0, b_x_reg};
        c_data_next.hue.den = (b_delta_reg == '0) ? DEN_W'(2) : {b_delta_reg, 1'b0};
        c_data_next.hue.quo = '0;
        c_data_next.sat.rem = {1'b0, b_delta_reg, 8'b0} - {9'b0, b_delta_reg};
        c_data_next.sat.den = (b_mx_reg == '0) ? DEN_W'(1) : {1'b0, b_mx_reg};
        c_data_next.sat.quo = '0;
        c_data_next.brightness = b_mx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_mx_reg     <= a_mx_next;
            a_mn_reg     <= a_mn_next;
            a_sector_reg <= a_sector_next;
            a_k_reg      <= a_k_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_mx_reg    <= a_mx_reg;
            b_delta_reg <= b_delta_next;
            b_x_reg     <= b_x_next;
        end
        if (c_ready && b_valid_reg)
            c_data_reg <= c_data_next;
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

/* rtl/rth_div_pipe.sv */
// ============================================================================
// RGB to HSV pixel converter: divider pipeline
// Two restoring dividers side by side, one quotient bit per stage.
// ============================================================================
module rth_div_pipe
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rth_pkg::div_stage_t        in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rth_pkg::QUO_W-1:0]  hue,
    output logic [rth_pkg::QUO_W-1:0]  saturation,
    output logic [rth_pkg::PIX_W-1:0]  brightness
);
    import rth_pkg::*;

    `include "rgb_to_hsv_pixel_defines.svh"

    localparam int LAST = QUO_W - 1;

    logic       valid_reg  [QUO_W];
    div_stage_t stage_reg  [QUO_W];
    div_stage_t stage_next [QUO_W];
    logic       vld_in     [QUO_W];
    div_stage_t data_in    [QUO_W];
    logic       rdy        [QUO_W+1];

    assign rdy[QUO_W] = out_ready;

    for (genvar j = 0; j < QUO_W; j++)
    begin : g_stage
        if (j == 0)
        begin : g_first
            assign vld_in[j]  = in_valid;
            assign data_in[j] = in_data;
        end
        else
        begin : g_rest
            assign vld_in[j]  = valid_reg[j-1];
            assign data_in[j] = stage_reg[j-1];
        end

        assign rdy[j] = !valid_reg[j] || rdy[j+1];

        // Stage j settles quotient bit QUO_W-1-j of both lanes.
        always_comb
        begin
            stage_next[j]     = data_in[j];
            stage_next[j].hue = div_step(data_in[j].hue, QUO_W - 1 - j);
            stage_next[j].sat = div_step(data_in[j].sat, QUO_W - 1 - j);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (rdy[j])
                valid_reg[j] <= vld_in[j];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j] && vld_in[j])
                stage_reg[j] <= stage_next[j];
        end
    end

    assign in_ready   = rdy[0];
    assign out_valid  = valid_reg[LAST];
    assign hue        = stage_reg[LAST].hue.quo;
    assign saturation = stage_reg[LAST].sat.quo;
    assign brightness = stage_reg[LAST].brightness;

    // A finished division leaves a remainder below its divisor.
    `RTH_ASSERT(a_hue_rem, !valid_reg[LAST] || (stage_reg[LAST].hue.rem < {8'b0, stage_reg[LAST].hue.den}), "hue remainder not below divisor")
    `RTH_ASSERT(a_sat_rem, !valid_reg[LAST] || (stage_reg[LAST].sat.rem < {8'b0, stage_reg[LAST].sat.den}), "saturation remainder not below divisor")
    `RTH_ASSERT_NEXT(a_enter, in_valid && rdy[0], valid_reg[0], "accepted transfer missing from first stage")
    `RTH_ASSERT_NEXT(a_hold, valid_reg[LAST] && !out_ready, valid_reg[LAST] && $stable(stage_reg[LAST]), "stalled result changed")

endmodule

/* rtl/rgb_to_hsv_pixel.sv */
// Pipeline: 3 front-end stages, then 8 divider stages, one quotient bit each;
// each input transfer passes through all of them in that order to its result.
// Throughput: one pixel per cycle unless the output stalls; every stage has its
// own valid bit and a stall only holds the stages that are full, so bubbles close up.
// Reset (rst_n low) clears all valid bits at once; no pixel data is reset.
// ============================================================================
// RGB to HSV pixel converter
// Streams 8-bit RGB pixels in and 8-bit hue, saturation and value out.
// ============================================================================
module rgb_to_hsv_pixel
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8], brightness [23:16]
);
    import rth_pkg::*;

    logic                 prep_valid;
    logic                 prep_ready;
    div_stage_t           prep_data;
    logic [QUO_W-1:0]     hue;
    logic [QUO_W-1:0]     saturation;
    logic [PIX_W-1:0]     brightness;

    rth_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    rth_div_pipe u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_data    (prep_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_axis_tdata = {brightness, saturation, hue};

endmodule
